/* src/wfaw_pkg.sv */
// shared constants, types and the channel blend function for the window frame store
`default_nettype none

package wfaw_pkg;

	localparam int SCREEN_COLS = 128;
	localparam int SCREEN_ROWS = 128;
	localparam int COL_W       = $clog2(SCREEN_COLS);
	localparam int ROW_W       = $clog2(SCREEN_ROWS);
	localparam int DEPTH       = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W      = $clog2(DEPTH);

	typedef logic [1:0] cmd_code_t;

	localparam cmd_code_t CMD_DEFINE = 2'd0;
	localparam cmd_code_t CMD_WRITE  = 2'd1;
	localparam cmd_code_t CMD_BLEND  = 2'd2;
	localparam cmd_code_t CMD_READ   = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic exec;
		logic mem_done;
		logic load_out;
	} dp_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic needs_mem;
	} dp_stat_t;

	// old + floor((src - old) * a / 256), low six bits; narrower channels take the low bits
	function automatic logic [5:0] blend_ch(input logic [5:0] src, input logic [5:0] old,
			input logic [7:0] a);
		logic signed [6:0]  diff;
		logic signed [15:0] diff_x;
		logic signed [15:0] a_x;
		logic signed [15:0] prod;
		diff   = $signed({1'b0, src}) - $signed({1'b0, old});
		diff_x = {{9{diff[6]}}, diff};
		a_x    = $signed({8'b0, a});
		prod   = diff_x * a_x;
		// arithmetic shift by 8 is the floor, only the low bits survive the mask
		return old + prod[13:8];
	endfunction

endpackage

`default_nettype wire

/* src/window_framebuffer_alpha_writer.sv */
// top level of the windowed rgb565 frame store with write, blend and read-back
//
// input channel s_*: one command per transfer, the kind in s_tuser, its operands in s_tdata
//   define sets a valid window and homes the cursor; write stores a pixel; blend mixes the
//   colour into the stored pixel by alpha/256; read returns the pixel; each pixel
//   command advances the cursor along the columns, then the rows, wrapping in the window
// output channel m_*: exactly one result transfer per command, in command order
// define and write pass the execute and finish states before the output register loads;
//   blend and read also pass the memory read state, for the registered frame store read port
// a new command is taken only after the last result is loaded into the output register;
//   the controller runs one command at a time and waits for the frame store read
// the output register holds a finished result, so a new command is taken while the
//   receiver stalls; a second result waits in the datapath result register until the
//   output register empties, and the input stays stalled meanwhile
// reset: cursor at 0,0 and window the full 128x128 screen; the frame store is not
//   cleared, software writes every pixel before reading or blending it
`default_nettype none

module window_framebuffer_alpha_writer
	import wfaw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // win_x, win_y, win_w, win_h, pixel_color, alpha, 2'b0
	input  wire logic [1:0]  s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // read_color
	output logic [1:0]       m_tuser   // status, read_valid
);

	dp_ctrl_t ctl;  // sequencing commands to the datapath
	dp_stat_t stat; // command kind seen by the controller

	// controller: handshakes and command sequencing
	wfaw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl),
		.stat     (stat)
	);

	// datapath: cursor, window, frame store, blend and result register
	wfaw_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.ctl     (ctl),
		.stat    (stat)
	);

endmodule

`default_nettype wire

/* src/wfaw_ctrl.sv */
// controller state machine sequencing one command at a time
`default_nettype none

module wfaw_ctrl
	import wfaw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output dp_ctrl_t      ctl,
	input  wire dp_stat_t stat
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_MEMRD  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       in_acc;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	assign ctl.load_item = in_acc;
	assign ctl.exec      = (state_q == ST_EXEC);
	assign ctl.mem_done  = (state_q == ST_MEMRD);
	assign ctl.load_out  = (state_q == ST_FINISH) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = stat.needs_mem ? ST_MEMRD : ST_FINISH;
			end
			ST_MEMRD: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_acc_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_EXEC)
		else $error("accepted item did not start execution");
	a_exec_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> (state_q == ST_MEMRD || state_q == ST_FINISH))
		else $error("bad state after execute");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> (state_q == ST_IDLE && out_valid_q))
		else $error("result load did not return to idle with valid output");
`endif

endmodule

`default_nettype wire

/* src/wfaw_dp.sv */
// datapath: item latch, window and cursor registers, frame store, blend and output register
`default_nettype none

module wfaw_dp
	import wfaw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  s_tuser,
	input  wire logic [55:0] s_tdata,
	output logic [15:0]      m_tdata,
	output logic [1:0]       m_tuser,
	input  wire dp_ctrl_t    ctl,
	output dp_stat_t         stat
);

	logic [15:0] mem [DEPTH];

	cmd_code_t   cmd_q;
	logic [6:0]  wx_q;
	logic [6:0]  wy_q;
	logic [7:0]  ww_q;
	logic [7:0]  wh_q;
	logic [15:0] color_q;
	logic [7:0]  alpha_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_first_q;
	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_first_q;
	logic [ROW_W-1:0] row_last_q;

	logic        res_status_q;
	logic        res_rvalid_q;
	logic [15:0] res_color_q;
	logic [15:0] rd_data_q;

	logic [ADDR_W-1:0] addr;
	logic              win_bad;
	logic              advance;
	logic              we;
	logic [15:0]       wdata;
	logic [15:0]       blended;
	logic [5:0]        red_n;
	logic [5:0]        grn_n;
	logic [5:0]        blu_n;

	assign stat.needs_mem = (cmd_q == CMD_BLEND) || (cmd_q == CMD_READ);

	assign addr = ADDR_W'(row_q) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_q);

	assign win_bad = (ww_q == 8'd0) || (wh_q == 8'd0)
		|| ((32'(wx_q) + 32'(ww_q)) > 32'(SCREEN_COLS))
		|| ((32'(wy_q) + 32'(wh_q)) > 32'(SCREEN_ROWS));

	assign red_n = blend_ch({1'b0, color_q[15:11]}, {1'b0, rd_data_q[15:11]}, alpha_q);
	assign grn_n = blend_ch(color_q[10:5], rd_data_q[10:5], alpha_q);
	assign blu_n = blend_ch({1'b0, color_q[4:0]}, {1'b0, rd_data_q[4:0]}, alpha_q);
	assign blended = {red_n[4:0], grn_n, blu_n[4:0]};

	assign advance = (ctl.exec && cmd_q == CMD_WRITE) || ctl.mem_done;
	assign we      = (ctl.exec && cmd_q == CMD_WRITE) || (ctl.mem_done && cmd_q == CMD_BLEND);
	assign wdata   = (cmd_q == CMD_WRITE) ? color_q : blended;

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[addr];
	end

	// item fields, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q   <= s_tuser;
			wx_q    <= s_tdata[6:0];
			wy_q    <= s_tdata[13:7];
			ww_q    <= s_tdata[21:14];
			wh_q    <= s_tdata[29:22];
			color_q <= s_tdata[45:30];
			alpha_q <= s_tdata[53:46];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			col_first_q <= '0;
			col_last_q  <= COL_W'(SCREEN_COLS - 1);
			row_first_q <= '0;
			row_last_q  <= ROW_W'(SCREEN_ROWS - 1);
		end else if (ctl.exec && cmd_q == CMD_DEFINE && !win_bad) begin
			col_first_q <= COL_W'(wx_q);
			row_first_q <= ROW_W'(wy_q);
			col_last_q  <= COL_W'(32'(wx_q) + 32'(ww_q) - 32'd1);
			row_last_q  <= ROW_W'(32'(wy_q) + 32'(wh_q) - 32'd1);
			col_q       <= COL_W'(wx_q);
			row_q       <= ROW_W'(wy_q);
		end else if (advance) begin
			if (col_q >= col_last_q) begin
				col_q <= col_first_q;
				row_q <= (row_q >= row_last_q) ? row_first_q : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// result of the current command
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			res_status_q <= (cmd_q == CMD_DEFINE) && win_bad;
			res_rvalid_q <= 1'b0;
			res_color_q  <= '0;
		end else if (ctl.mem_done && cmd_q == CMD_READ) begin
			res_rvalid_q <= 1'b1;
			res_color_q  <= rd_data_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			m_tuser <= {res_rvalid_q, res_status_q};
			m_tdata <= res_color_q;
		end
	end

`ifndef SYNTH
	a_col_in_win: assert property (@(posedge clk) disable iff (!arst_n)
		col_q >= col_first_q && col_q <= col_last_q)
		else $error("column cursor left the window");
	a_row_in_win: assert property (@(posedge clk) disable iff (!arst_n)
		row_q >= row_first_q && row_q <= row_last_q)
		else $error("row cursor left the window");
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && cmd_q == CMD_DEFINE && win_bad |=> $stable(col_first_q) && $stable(row_q))
		else $error("rejected window changed state");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for the windowed rgb565 frame store with write, blend and read-back
`timescale 1ns / 1ps

module tb_top;
	import wfaw_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int STALL_LIMIT  = 2000;	// cycles without any transfer before the run is abandoned
	localparam int HOLD_CYCLES  = 300;	// receiver hold-off for the backpressure test
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1780;

	// one command as the sender sees it
	typedef struct {
		cmd_code_t   cmd;
		logic [6:0]  wx;
		logic [6:0]  wy;
		logic [7:0]  ww;
		logic [7:0]  wh;
		logic [15:0] color;
		logic [7:0]  alpha;
	} fb_cmd_t;

	// one result transfer as the receiver should see it
	typedef struct {
		logic        status;
		logic        rvalid;
		logic [15:0] color;
	} fb_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;	// win_x, win_y, win_w, win_h, pixel_color, alpha, 2'b0
	logic [1:0]  s_tuser;	// cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;	// read_color
	logic [1:0]  m_tuser;	// status, read_valid

	// shadow copy of the block: frame store, window and cursor
	logic [15:0] shadow_store [DEPTH];
	bit          pixel_written [DEPTH];
	logic [6:0]  cur_col, cur_row;
	logic [6:0]  win_col_first, win_col_last, win_row_first, win_row_last;

	fb_result_t  pending_results [$];
	int          mismatch_count;
	int          idle_cycles;
	int          items_sent;
	bit          no_gaps;		// both sides run without idling while set
	bit          long_hold_req;	// asks the receiver for one long hold-off

	window_framebuffer_alpha_writer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// old + floor((src - old) * a / 256), kept to the channel width
	function automatic logic [5:0] mix_channel(input int src, input int old, input int a,
			input int mask);
		int prod;
		prod = (src - old) * a;
		return 6'((old + (prod >>> 8)) & mask);
	endfunction

	function automatic int cursor_index();
		return int'(cur_col) + int'(cur_row) * SCREEN_COLS;
	endfunction

	// step along the columns, then the rows, wrapping inside the window
	task automatic step_cursor();
		if (cur_col >= win_col_last) begin
			cur_col = win_col_first;
			if (cur_row >= win_row_last)
				cur_row = win_row_first;
			else
				cur_row = cur_row + 7'd1;
		end else begin
			cur_col = cur_col + 7'd1;
		end
	endtask

	// apply one accepted command to the shadow state and queue the result it must give
	task automatic apply_command(input fb_cmd_t c);
		fb_result_t exp_res;
		int         idx;
		logic [15:0] old;
		logic [4:0] r, b;
		logic [5:0] g;
		exp_res = '{status: 1'b0, rvalid: 1'b0, color: 16'h0000};
		idx = cursor_index();
		case (c.cmd)
			CMD_DEFINE: begin
				if (c.ww == 0 || c.wh == 0 || int'(c.wx) + int'(c.ww) > SCREEN_COLS ||
						int'(c.wy) + int'(c.wh) > SCREEN_ROWS) begin
					exp_res.status = 1'b1;
				end else begin
					win_col_first = c.wx;
					win_col_last  = 7'(int'(c.wx) + int'(c.ww) - 1);
					win_row_first = c.wy;
					win_row_last  = 7'(int'(c.wy) + int'(c.wh) - 1);
					cur_col       = c.wx;
					cur_row       = c.wy;
				end
			end
			CMD_WRITE: begin
				shadow_store[idx]  = c.color;
				pixel_written[idx] = 1'b1;
				step_cursor();
			end
			CMD_BLEND: begin
				old = shadow_store[idx];
				r = 5'(mix_channel(int'(c.color[15:11]), int'(old[15:11]), int'(c.alpha),
					'h1F));
				g = mix_channel(int'(c.color[10:5]), int'(old[10:5]), int'(c.alpha), 'h3F);
				b = 5'(mix_channel(int'(c.color[4:0]), int'(old[4:0]), int'(c.alpha), 'h1F));
				shadow_store[idx] = {r, g, b};
				step_cursor();
			end
			default: begin
				exp_res.rvalid = 1'b1;
				exp_res.color  = shadow_store[idx];
				step_cursor();
			end
		endcase
		pending_results.push_back(exp_res);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// offer one command and wait for its transfer; valid stays high into a back-to-back item
	task automatic send_command(input fb_cmd_t c);
		int gap;
		// a pixel never written is never read: such a command becomes a write
		if ((c.cmd == CMD_BLEND || c.cmd == CMD_READ) && !pixel_written[cursor_index()])
			c.cmd = CMD_WRITE;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.cmd;
		s_tdata  <= {2'b00, c.alpha, c.color, c.wh, c.ww, c.wy, c.wx};
		do @(posedge clk); while (!s_tready);
		apply_command(c);
		items_sent++;
	endtask

	function automatic fb_cmd_t make_cmd(input cmd_code_t cmd, input logic [15:0] color,
			input logic [7:0] alpha);
		fb_cmd_t c;
		c.cmd   = cmd;
		c.wx    = 7'($urandom);
		c.wy    = 7'($urandom);
		c.ww    = 8'($urandom);
		c.wh    = 8'($urandom);
		c.color = color;
		c.alpha = alpha;
		return c;
	endfunction

	function automatic fb_cmd_t make_define(input int x, input int y, input int w, input int h);
		fb_cmd_t c;
		c    = make_cmd(CMD_DEFINE, 16'($urandom), 8'($urandom));
		c.wx = 7'(x);
		c.wy = 7'(y);
		c.ww = 8'(w);
		c.wh = 8'(h);
		return c;
	endfunction

	// receiver: random stall per result, one long hold-off on request, checks every transfer
	initial begin
		fb_result_t exp_res;
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result transfer", int'(m_tdata), 0);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tuser[0] !== exp_res.status)
					report_mismatch("status", int'(m_tuser[0]), int'(exp_res.status));
				if (m_tuser[1] !== exp_res.rvalid)
					report_mismatch("read_valid", int'(m_tuser[1]), int'(exp_res.rvalid));
				if (m_tdata !== exp_res.color)
					report_mismatch("read_color", int'(m_tdata), int'(exp_res.color));
			end
		end
	end

	// watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout at %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("** window_framebuffer_alpha_writer: FAILED **");
			$finish;
		end
	end

	// window accept and reject, including the edges of the screen
	task automatic test_window_define();
		send_command(make_define(0, 0, 128, 128));
		send_command(make_define(5, 5, 0, 4));		// zero width
		send_command(make_define(5, 5, 4, 0));		// zero height
		send_command(make_define(127, 0, 2, 1));	// one column past the right edge
		send_command(make_define(0, 100, 1, 29));	// one row past the bottom edge
		send_command(make_define(0, 0, 255, 255));
		send_command(make_define(127, 127, 1, 1));
	endtask

	// write, read-back with wrap, blend extremes on a 2x2 window in the corner
	task automatic test_pixel_ops();
		send_command(make_define(126, 126, 2, 2));
		send_command(make_cmd(CMD_WRITE, 16'h0000, 8'hFF));
		send_command(make_cmd(CMD_WRITE, 16'hFFFF, 8'h00));
		send_command(make_cmd(CMD_WRITE, 16'hF800, 8'h80));
		send_command(make_cmd(CMD_WRITE, 16'h07E0, 8'h01));
		repeat (4) send_command(make_cmd(CMD_READ, 16'hFFFF, 8'hFF));
		send_command(make_cmd(CMD_BLEND, 16'hFFFF, 8'hFF));	// from black toward white
		send_command(make_cmd(CMD_BLEND, 16'h0000, 8'hFF));	// from white toward black
		send_command(make_cmd(CMD_BLEND, 16'h001F, 8'h00));	// zero alpha keeps old pixel
		send_command(make_cmd(CMD_BLEND, 16'hFFFF, 8'h80));
		repeat (4) send_command(make_cmd(CMD_READ, 16'h0000, 8'h00));
		// single pixel window wraps in both directions at once
		send_command(make_define(0, 0, 1, 1));
		send_command(make_cmd(CMD_WRITE, 16'h1234, 8'h00));
		send_command(make_cmd(CMD_READ, 16'h0000, 8'h00));
		send_command(make_cmd(CMD_READ, 16'h0000, 8'h00));
	endtask

	// a stretch with no idling on either side
	task automatic test_back_to_back();
		no_gaps = 1'b1;
		send_command(make_define(10, 20, 8, 4));
		repeat (32) send_command(make_cmd(CMD_WRITE, 16'($urandom), 8'($urandom)));
		repeat (64) send_command(make_cmd(cmd_code_t'($urandom_range(CMD_WRITE, CMD_READ)),
			16'($urandom), 8'($urandom)));
		no_gaps = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (24) send_command(make_cmd(cmd_code_t'($urandom_range(CMD_WRITE, CMD_READ)),
			16'($urandom), 8'($urandom)));
		no_gaps = 1'b0;
	endtask

	// mostly well-formed window sessions with random content, some raw noise
	task automatic test_random_traffic();
		int start, x, y, w, h, fill, n;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 9) == 0) begin
					w = $urandom_range(1, 128);
					h = $urandom_range(1, 128);
				end else begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 8);
				end
				x = $urandom_range(0, SCREEN_COLS - w);
				y = $urandom_range(0, SCREEN_ROWS - h);
				send_command(make_define(x, y, w, h));
				fill = (w * h > 64) ? 64 : w * h;
				repeat (fill) send_command(make_cmd(CMD_WRITE, 16'($urandom), 8'($urandom)));
				n = $urandom_range(8, 40);
				repeat (n) send_command(make_cmd(cmd_code_t'($urandom_range(CMD_WRITE, CMD_READ)),
					16'($urandom), 8'($urandom)));
			end else begin
				n = $urandom_range(1, 5);
				repeat (n) send_command(make_cmd(cmd_code_t'($urandom_range(CMD_DEFINE, CMD_READ)),
					16'($urandom), 8'($urandom)));
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = CMD_DEFINE;
		mismatch_count = 0;
		idle_cycles    = 0;
		items_sent     = 0;
		no_gaps        = 1'b0;
		long_hold_req  = 1'b0;
		cur_col        = 7'd0;
		cur_row        = 7'd0;
		win_col_first  = 7'd0;
		win_col_last   = 7'(SCREEN_COLS - 1);
		win_row_first  = 7'd0;
		win_row_last   = 7'(SCREEN_ROWS - 1);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_define();
		test_pixel_ops();
		test_back_to_back();
		test_backpressure();
		test_random_traffic();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** window_framebuffer_alpha_writer: PASSED **");
		else
			$display("** window_framebuffer_alpha_writer: FAILED **");
		$finish;
	end

endmodule
